// ===== hdl/dlt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the DH link transform.
package dlt_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN = 24;
    localparam int CORDIC_N = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

    localparam logic signed [20:0] ANG_LIM = 21'sd411775;
    localparam logic signed [20:0] ANG_PI = 21'sd205887;
    localparam logic signed [20:0] ANG_HALF_PI = 21'sd102944;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    localparam logic [2:0] REG_CONVENTION = 3'd0;
    localparam logic [2:0] REG_FREE_SELECT = 3'd1;
    localparam logic [2:0] REG_LINK_LENGTH = 3'd2;
    localparam logic [2:0] REG_LINK_TWIST = 3'd3;
    localparam logic [2:0] REG_LINK_OFFSET = 3'd4;
    localparam logic [2:0] REG_JOINT_ANGLE = 3'd5;

    localparam logic [2:0] FREE_LENGTH = 3'd1;
    localparam logic [2:0] FREE_TWIST = 3'd2;
    localparam logic [2:0] FREE_OFFSET = 3'd3;
    localparam logic [2:0] FREE_ANGLE = 3'd4;

    localparam logic [1:0] ROW_0 = 2'd0;
    localparam logic [1:0] ROW_1 = 2'd1;
    localparam logic [1:0] ROW_2 = 2'd2;

    typedef struct packed {
        logic signed [31:0] z_theta;
        logic neg_theta;
        logic signed [31:0] z_alpha;
        logic neg_alpha;
        logic signed [31:0] len;
        logic signed [31:0] offs;
        logic conv;
        logic written;
    } dlt_job_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } dlt_lane_t;

    typedef struct packed {
        dlt_lane_t th;
        logic neg_theta;
        dlt_lane_t al;
        logic neg_alpha;
        logic signed [31:0] len;
        logic signed [31:0] offs;
        logic conv;
        logic written;
    } dlt_stage_t;

    typedef struct packed {
        logic signed [31:0] st;
        logic signed [31:0] ct;
        logic signed [31:0] sa;
        logic signed [31:0] ca;
        logic signed [31:0] len;
        logic signed [31:0] offs;
        logic conv;
        logic written;
    } dlt_sc_t;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0: r = 34'sd843314856;
            5'd1: r = 34'sd497837829;
            5'd2: r = 34'sd263043836;
            5'd3: r = 34'sd133525158;
            5'd4: r = 34'sd67021686;
            5'd5: r = 34'sd33543515;
            5'd6: r = 34'sd16775850;
            5'd7: r = 34'sd8388437;
            5'd8: r = 34'sd4194282;
            5'd9: r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    function automatic dlt_lane_t cordic_iter(input dlt_lane_t l, input logic [4:0] i);
        dlt_lane_t r;
        if (!l.z[33])
        begin
            r.x = l.x - (l.y >>> i);
            r.y = l.y + (l.x >>> i);
            r.z = l.z - atan_q30(i);
        end
        else
        begin
            r.x = l.x + (l.y >>> i);
            r.y = l.y - (l.x >>> i);
            r.z = l.z + atan_q30(i);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] fix_q30(input logic signed [33:0] v,
                                                  input logic neg);
        logic signed [33:0] n;
        n = neg ? -v : v;
        if (n > ONE_Q30)
            n = ONE_Q30;
        else if (n < -ONE_Q30)
            n = -ONE_Q30;
        return n[31:0];
    endfunction

    function automatic logic signed [15:0] one14(input logic signed [31:0] v);
        logic signed [32:0] s;
        s = 33'(v) + 33'sd32768;
        return 16'(s >>> 16);
    endfunction

    function automatic logic signed [15:0] mul14(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + (64'sd1 <<< 45);
        return 16'(p >>> 46);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -35'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] trans(input logic signed [31:0] len,
                                                input logic signed [31:0] c);
        logic signed [63:0] p;
        p = 64'(len) * 64'(c) + (64'sd1 <<< 29);
        p = p >>> 30;
        return sat32(p[34:0]);
    endfunction

    function automatic logic signed [31:0] negsat(input logic signed [31:0] v);
        return sat32(-35'(v));
    endfunction

endpackage

// ===== hdl/dlt_front.sv =====
`timescale 1ns / 1ps
// Front end: link registers, joint update and angle classification.
module dlt_front (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data,
    input  logic in_valid,
    input  logic signed [31:0] joint_value,
    input  logic q_full,
    output logic accept,
    output dlt_pkg::dlt_job_t job
);

    logic conv_reg;
    logic [2:0] free_reg;
    logic signed [31:0] len_reg, len_next;
    logic signed [19:0] twist_reg, twist_next;
    logic signed [31:0] offs_reg, offs_next;
    logic signed [19:0] angle_reg, angle_next;
    logic signed [19:0] q_ang;
    logic written;

    function automatic logic [32:0] classify(input logic signed [19:0] raw);
        logic signed [20:0] a;
        logic neg;
        logic signed [31:0] z;
        a = 21'(raw);
        neg = 1'b0;
        if (a > dlt_pkg::ANG_LIM)
            a = dlt_pkg::ANG_LIM;
        else if (a < -dlt_pkg::ANG_LIM)
            a = -dlt_pkg::ANG_LIM;
        if (a > dlt_pkg::ANG_PI)
            a = a - dlt_pkg::ANG_LIM;
        if (a < -dlt_pkg::ANG_PI)
            a = a + dlt_pkg::ANG_LIM;
        if (a > dlt_pkg::ANG_HALF_PI)
        begin
            a = a - dlt_pkg::ANG_PI;
            neg = 1'b1;
        end
        else if (a < -dlt_pkg::ANG_HALF_PI)
        begin
            a = a + dlt_pkg::ANG_PI;
            neg = 1'b1;
        end
        z = 32'(a) <<< 14;
        return {z, neg};
    endfunction

    assign accept = in_valid && !q_full;

    always_comb
    begin
        if (joint_value > 32'(dlt_pkg::ANG_LIM))
            q_ang = dlt_pkg::ANG_LIM[19:0];
        else if (joint_value < -32'(dlt_pkg::ANG_LIM))
            q_ang = 20'(-dlt_pkg::ANG_LIM);
        else
            q_ang = joint_value[19:0];
        len_next = len_reg;
        twist_next = twist_reg;
        offs_next = offs_reg;
        angle_next = angle_reg;
        written = 1'b1;
        unique case (free_reg)
            dlt_pkg::FREE_LENGTH: len_next = joint_value;
            dlt_pkg::FREE_TWIST: twist_next = q_ang;
            dlt_pkg::FREE_OFFSET: offs_next = joint_value;
            dlt_pkg::FREE_ANGLE: angle_next = q_ang;
            default: written = 1'b0;
        endcase
        {job.z_theta, job.neg_theta} = classify(angle_next);
        {job.z_alpha, job.neg_alpha} = classify(twist_next);
        job.len = len_next;
        job.offs = offs_next;
        job.conv = conv_reg;
        job.written = written;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_reg <= 1'b1;
            free_reg <= 3'd0;
            len_reg <= '0;
            twist_reg <= '0;
            offs_reg <= '0;
            angle_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dlt_pkg::REG_CONVENTION: conv_reg <= cfg_data[0];
                dlt_pkg::REG_FREE_SELECT: free_reg <= cfg_data[2:0];
                dlt_pkg::REG_LINK_LENGTH: len_reg <= cfg_data;
                dlt_pkg::REG_LINK_TWIST: twist_reg <= cfg_data[19:0];
                dlt_pkg::REG_LINK_OFFSET: offs_reg <= cfg_data;
                dlt_pkg::REG_JOINT_ANGLE: angle_reg <= cfg_data[19:0];
                default: ;
            endcase
        end
        else if (accept)
        begin
            len_reg <= len_next;
            twist_reg <= twist_next;
            offs_reg <= offs_next;
            angle_reg <= angle_next;
        end
    end

endmodule

// ===== hdl/dlt_queue.sv =====
`timescale 1ns / 1ps
// Two-entry request queue between the front end and the back end.
module dlt_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  dlt_pkg::dlt_job_t push_data,
    input  logic pop,
    output logic full,
    output logic avail,
    output dlt_pkg::dlt_job_t pop_data
);

    dlt_pkg::dlt_job_t mem_reg [0:1];
    logic wr_reg, rd_reg;
    logic [1:0] count_reg;
    logic do_pop;

    assign full = (count_reg == 2'd2);
    assign avail = (count_reg != 2'd0);
    assign pop_data = mem_reg[rd_reg];
    assign do_pop = pop && avail;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (do_pop)
                rd_reg <= !rd_reg;
            count_reg <= count_reg + 2'(push) - 2'(do_pop);
        end
    end

endmodule

// ===== hdl/dlt_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined CORDIC giving sine and cosine of joint angle and twist.
module dlt_cordic (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic job_valid,
    input  dlt_pkg::dlt_job_t job,
    output logic sc_valid,
    output dlt_pkg::dlt_sc_t sc
);

    localparam int N = dlt_pkg::CORDIC_N;

    dlt_pkg::dlt_stage_t stg_reg [0:N];
    logic [N:0] vld_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg[0].th.x <= dlt_pkg::CORDIC_GAIN;
            stg_reg[0].th.y <= '0;
            stg_reg[0].th.z <= 34'(job.z_theta);
            stg_reg[0].neg_theta <= job.neg_theta;
            stg_reg[0].al.x <= dlt_pkg::CORDIC_GAIN;
            stg_reg[0].al.y <= '0;
            stg_reg[0].al.z <= 34'(job.z_alpha);
            stg_reg[0].neg_alpha <= job.neg_alpha;
            stg_reg[0].len <= job.len;
            stg_reg[0].offs <= job.offs;
            stg_reg[0].conv <= job.conv;
            stg_reg[0].written <= job.written;
            for (int k = 0; k < N; k++)
            begin
                stg_reg[k+1].th <= dlt_pkg::cordic_iter(stg_reg[k].th, 5'(k));
                stg_reg[k+1].neg_theta <= stg_reg[k].neg_theta;
                stg_reg[k+1].al <= dlt_pkg::cordic_iter(stg_reg[k].al, 5'(k));
                stg_reg[k+1].neg_alpha <= stg_reg[k].neg_alpha;
                stg_reg[k+1].len <= stg_reg[k].len;
                stg_reg[k+1].offs <= stg_reg[k].offs;
                stg_reg[k+1].conv <= stg_reg[k].conv;
                stg_reg[k+1].written <= stg_reg[k].written;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N-1:0], job_valid};
    end

    assign sc_valid = vld_reg[N];

    always_comb
    begin
        sc.ct = dlt_pkg::fix_q30(stg_reg[N].th.x, stg_reg[N].neg_theta);
        sc.st = dlt_pkg::fix_q30(stg_reg[N].th.y, stg_reg[N].neg_theta);
        sc.ca = dlt_pkg::fix_q30(stg_reg[N].al.x, stg_reg[N].neg_alpha);
        sc.sa = dlt_pkg::fix_q30(stg_reg[N].al.y, stg_reg[N].neg_alpha);
        sc.len = stg_reg[N].len;
        sc.offs = stg_reg[N].offs;
        sc.conv = stg_reg[N].conv;
        sc.written = stg_reg[N].written;
    end

endmodule

// ===== hdl/dlt_emit.sv =====
`timescale 1ns / 1ps
// Back end row sequencer: builds one transform row per cycle into the output register unless stalled.
module dlt_emit (
    input  logic clk,
    input  logic rst_n,
    input  logic sc_valid,
    input  dlt_pkg::dlt_sc_t sc,
    output logic take,
    input  logic out_stall,
    output logic out_valid,
    output logic [1:0] row_index,
    output logic signed [15:0] rot_col0,
    output logic signed [15:0] rot_col1,
    output logic signed [15:0] rot_col2,
    output logic signed [31:0] trans_part,
    output logic last_row,
    output logic written
);

    dlt_pkg::dlt_sc_t sc_reg;
    logic sc_valid_reg;
    logic [1:0] row_reg;
    logic out_valid_reg;
    logic [1:0] row_out_reg;
    logic signed [15:0] c0_reg, c1_reg, c2_reg;
    logic signed [31:0] t_reg;
    logic last_reg, wr_reg;
    logic issue;
    logic signed [31:0] m1a, m1b, m2a, m2b, tl, tc;
    logic signed [15:0] m1, m2, c0_next, c1_next, c2_next;
    logic signed [31:0] tp, t_next;

    assign issue = sc_valid_reg && (!out_valid_reg || !out_stall);
    assign take = !sc_valid_reg || (issue && row_reg == dlt_pkg::ROW_2);

    always_comb
    begin
        m1a = sc_reg.st;
        m1b = sc_reg.ca;
        m2a = sc_reg.ct;
        m2b = sc_reg.sa;
        tl = sc_reg.conv ? sc_reg.offs : sc_reg.len;
        tc = sc_reg.ct;
        case (row_reg)
            dlt_pkg::ROW_0:
            begin
                m2a = sc_reg.st;
            end
            dlt_pkg::ROW_1:
            begin
                if (sc_reg.conv)
                begin
                    m2b = sc_reg.ca;
                    tc = sc_reg.sa;
                end
                else
                begin
                    m1a = sc_reg.ct;
                    tc = sc_reg.st;
                end
            end
            default:
            begin
                m1b = sc_reg.sa;
                tc = sc_reg.ca;
            end
        endcase
        m1 = dlt_pkg::mul14(m1a, m1b);
        m2 = dlt_pkg::mul14(m2a, m2b);
        tp = dlt_pkg::trans(tl, tc);
        c0_next = '0;
        c1_next = '0;
        c2_next = '0;
        t_next = '0;
        if (!sc_reg.conv)
        begin
            case (row_reg)
                dlt_pkg::ROW_0:
                begin
                    c0_next = dlt_pkg::one14(sc_reg.ct);
                    c1_next = -m1;
                    c2_next = m2;
                    t_next = tp;
                end
                dlt_pkg::ROW_1:
                begin
                    c0_next = dlt_pkg::one14(sc_reg.st);
                    c1_next = m1;
                    c2_next = -m2;
                    t_next = tp;
                end
                default:
                begin
                    c1_next = dlt_pkg::one14(sc_reg.sa);
                    c2_next = dlt_pkg::one14(sc_reg.ca);
                    t_next = sc_reg.offs;
                end
            endcase
        end
        else
        begin
            case (row_reg)
                dlt_pkg::ROW_0:
                begin
                    c0_next = dlt_pkg::one14(sc_reg.ct);
                    c1_next = -dlt_pkg::one14(sc_reg.st);
                    t_next = sc_reg.len;
                end
                dlt_pkg::ROW_1:
                begin
                    c0_next = m1;
                    c1_next = m2;
                    c2_next = -dlt_pkg::one14(sc_reg.sa);
                    t_next = dlt_pkg::negsat(tp);
                end
                default:
                begin
                    c0_next = m1;
                    c1_next = m2;
                    c2_next = dlt_pkg::one14(sc_reg.ca);
                    t_next = tp;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            sc_reg <= sc;
        if (issue)
        begin
            row_out_reg <= row_reg;
            c0_reg <= c0_next;
            c1_reg <= c1_next;
            c2_reg <= c2_next;
            t_reg <= t_next;
            last_reg <= (row_reg == dlt_pkg::ROW_2);
            wr_reg <= sc_reg.written;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_valid_reg <= 1'b0;
            row_reg <= dlt_pkg::ROW_0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                sc_valid_reg <= sc_valid;
                row_reg <= dlt_pkg::ROW_0;
            end
            else if (issue)
                row_reg <= row_reg + 2'd1;
            if (issue)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_index = row_out_reg;
    assign rot_col0 = c0_reg;
    assign rot_col1 = c1_reg;
    assign rot_col2 = c2_reg;
    assign trans_part = t_reg;
    assign last_row = last_reg;
    assign written = wr_reg;

endmodule

// ===== hdl/dh_link_transform.sv =====
`timescale 1ns / 1ps
// Top level of the Denavit-Hartenberg link transform.
// Each request on the input channel carries one joint value. The value replaces
// the link parameter picked by free_select, and the block then emits three
// requests on the output channel, rows 0, 1 and 2 of the rotation with one
// translation component each; last_row marks row 2.
// The configuration port writes the six link registers; cfg_index selects the
// register and writes outside the list are ignored.
// The front end takes a request when its two-entry queue has room. The back end
// runs both angles through a CORDIC pipeline of CORDIC_STEPS stages and then
// builds one row per cycle while the output is not stalled, the row sequencer
// sharing one output register; it takes the next item as it issues row 2. The
// CORDIC pipeline only advances when the row sequencer takes a new item, so
// under load a request waits in each stage for the rows ahead to be emitted.
// While out_stall is high a valid output row holds, and the pipeline freezes
// once the row sequencer holds an item; requests keep entering until the queue
// is full, and in_stall rises.
// Reset clears all control state and sets the registers to modified
// convention, nothing free and all parameters zero.
module dh_link_transform (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic signed [31:0] joint_value,
    output logic out_valid,
    input  logic out_stall,
    output logic [1:0] row_index,
    output logic signed [15:0] rot_col0,
    output logic signed [15:0] rot_col1,
    output logic signed [15:0] rot_col2,
    output logic signed [31:0] trans_part,
    output logic last_row,
    output logic written
);

    dlt_pkg::dlt_job_t job, q_job;
    dlt_pkg::dlt_sc_t sc;
    logic accept, q_full, q_avail, take, sc_valid;

    dlt_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .joint_value(joint_value),
        .q_full(q_full),
        .accept(accept),
        .job(job)
    );

    dlt_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(accept),
        .push_data(job),
        .pop(take),
        .full(q_full),
        .avail(q_avail),
        .pop_data(q_job)
    );

    dlt_cordic u_cordic (
        .clk(clk),
        .rst_n(rst_n),
        .en(take),
        .job_valid(q_avail),
        .job(q_job),
        .sc_valid(sc_valid),
        .sc(sc)
    );

    dlt_emit u_emit (
        .clk(clk),
        .rst_n(rst_n),
        .sc_valid(sc_valid),
        .sc(sc),
        .take(take),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .row_index(row_index),
        .rot_col0(rot_col0),
        .rot_col1(rot_col1),
        .rot_col2(rot_col2),
        .trans_part(trans_part),
        .last_row(last_row),
        .written(written)
    );

    assign in_stall = q_full;

`ifndef SYNTH
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_row == (row_index == dlt_pkg::ROW_2)))
        else $error("last_row does not match row 2");
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (row_index != 2'd3))
        else $error("row index out of range");
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rot_col1 >= -16'sd16384 && rot_col1 <= 16'sd16384))
        else $error("rotation entry out of range");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the DH link transform with its own row predictor.
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 3 * dlt_pkg::CORDIC_STEPS + 40;
    localparam longint A_LIM = 411775;
    localparam longint A_PI = 205887;
    localparam longint A_HALF = 102944;

    typedef struct {
        logic [1:0] row;
        logic signed [15:0] c0;
        logic signed [15:0] c1;
        logic signed [15:0] c2;
        logic signed [31:0] tr;
        logic last;
        logic wr;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] joint_value;
    logic out_valid;
    logic out_stall;
    logic [1:0] row_index;
    logic signed [15:0] rot_col0;
    logic signed [15:0] rot_col1;
    logic signed [15:0] rot_col2;
    logic signed [31:0] trans_part;
    logic last_row;
    logic written;

    row_t expected_rows[$];
    int error_count = 0;
    int rows_seen = 0;
    int joints_sent = 0;
    int idle_cycles = 0;
    bit hold_off = 0;
    bit burst_mode = 1;

    bit m_conv;
    logic [2:0] m_free;
    longint m_len;
    longint m_twist;
    longint m_offs;
    longint m_theta;

    dh_link_transform i_dut (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint lim(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint atan_entry(int i);
        longint t[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
            131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
        return t[i];
    endfunction

    task automatic sine_cosine(input longint ang, output longint s, output longint c);
        longint x;
        longint y;
        longint z;
        longint t;
        longint a;
        bit flip;
        x = 652032874;
        y = 0;
        flip = 0;
        a = lim(ang, -A_LIM, A_LIM);
        if (a > A_PI) a -= A_LIM;
        if (a < -A_PI) a += A_LIM;
        if (a > A_HALF)
        begin
            a -= A_PI;
            flip = 1;
        end
        else if (a < -A_HALF)
        begin
            a += A_PI;
            flip = 1;
        end
        z = a * 16384;
        for (int i = 0; i < dlt_pkg::CORDIC_N; i++)
        begin
            if (z >= 0)
            begin
                t = x - shr(y, i);
                y = y + shr(x, i);
                x = t;
                z -= atan_entry(i);
            end
            else
            begin
                t = x + shr(y, i);
                y = y - shr(x, i);
                x = t;
                z += atan_entry(i);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = lim(x, -64'sd1073741824, 64'sd1073741824);
        s = lim(y, -64'sd1073741824, 64'sd1073741824);
    endtask

    function automatic longint rnd1(longint v);
        return shr(v + 32768, 16);
    endfunction

    function automatic longint rnd2(longint a, longint b);
        return shr(a * b + (64'sd1 <<< 45), 46);
    endfunction

    function automatic longint scale_len(longint l, longint c);
        return lim(shr(l * c + (64'sd1 <<< 29), 30), -64'sd2147483648, 64'sd2147483647);
    endfunction

    task automatic predict_rows(input logic signed [31:0] q);
        longint st, ct, sa, ca;
        longint e[3][4];
        bit wr;
        row_t r;
        wr = 1;
        case (m_free)
            dlt_pkg::FREE_LENGTH: m_len = q;
            dlt_pkg::FREE_TWIST: m_twist = lim(q, -A_LIM, A_LIM);
            dlt_pkg::FREE_OFFSET: m_offs = q;
            dlt_pkg::FREE_ANGLE: m_theta = lim(q, -A_LIM, A_LIM);
            default: wr = 0;
        endcase
        sine_cosine(m_theta, st, ct);
        sine_cosine(m_twist, sa, ca);
        if (!m_conv)
        begin
            e[0] = '{rnd1(ct), -rnd2(st, ca), rnd2(st, sa), scale_len(m_len, ct)};
            e[1] = '{rnd1(st), rnd2(ct, ca), -rnd2(ct, sa), scale_len(m_len, st)};
            e[2] = '{0, rnd1(sa), rnd1(ca), m_offs};
        end
        else
        begin
            e[0] = '{rnd1(ct), -rnd1(st), 0, m_len};
            e[1] = '{rnd2(st, ca), rnd2(ct, ca), -rnd1(sa),
                     lim(-scale_len(m_offs, sa), -64'sd2147483648, 64'sd2147483647)};
            e[2] = '{rnd2(st, sa), rnd2(ct, sa), rnd1(ca), scale_len(m_offs, ca)};
        end
        for (int k = 0; k < 3; k++)
        begin
            r.row = 2'(k);
            r.c0 = 16'(e[k][0]);
            r.c1 = 16'(e[k][1]);
            r.c2 = 16'(e[k][2]);
            r.tr = 32'(e[k][3]);
            r.last = (k == 2);
            r.wr = wr;
            expected_rows.push_back(r);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            dlt_pkg::REG_CONVENTION: m_conv = val[0];
            dlt_pkg::REG_FREE_SELECT: m_free = val[2:0];
            dlt_pkg::REG_LINK_LENGTH: m_len = longint'(signed'(val));
            dlt_pkg::REG_LINK_TWIST: m_twist = longint'(signed'(val[19:0]));
            dlt_pkg::REG_LINK_OFFSET: m_offs = longint'(signed'(val));
            dlt_pkg::REG_JOINT_ANGLE: m_theta = longint'(signed'(val[19:0]));
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        in_valid <= 0;
        while (expected_rows.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_joint(input logic signed [31:0] q);
        if (burst_mode && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1;
        joint_value <= q;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_rows(q);
        joints_sent++;
    endtask

    task automatic set_link(input bit conv, input logic [2:0] fs, input logic [31:0] len,
                            input logic [31:0] tw, input logic [31:0] offs,
                            input logic [31:0] th);
        wait_idle();
        write_reg(dlt_pkg::REG_CONVENTION, {31'd0, conv});
        write_reg(dlt_pkg::REG_FREE_SELECT, {29'd0, fs});
        write_reg(dlt_pkg::REG_LINK_LENGTH, len);
        write_reg(dlt_pkg::REG_LINK_TWIST, tw);
        write_reg(dlt_pkg::REG_LINK_OFFSET, offs);
        write_reg(dlt_pkg::REG_JOINT_ANGLE, th);
        cfg_we <= 0;
    endtask

    function automatic logic signed [31:0] random_angle();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 823550) - 411775;
            1: return $urandom_range(0, 8) * 51472 - 205887;
            2: return $urandom();
            default: return $urandom_range(0, 4) * 102944 - 205888 + $urandom_range(0, 2) - 1;
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_joint(32'sd12345);
        send_joint(-32'sd1);
    endtask

    task automatic test_directed_extremes();
        logic signed [31:0] ext[6] = '{32'h7fffffff, 32'h80000000, 0, 411775, -411775, 205887};
        for (int c = 0; c < 2; c++)
        begin
            for (int f = 1; f <= 4; f++)
            begin
                set_link(c[0], f[2:0], 32'h7fffffff, 20'h7ffff, 32'h80000000, 20'h80000);
                send_joint(ext[$urandom_range(0, 5)]);
                send_joint(ext[f % 6]);
            end
        end
        set_link(1, 3'd0, 32'h80000000, 32'd102944, 32'h80000000, 32'd308831);
        send_joint(32'sd5);
        set_link(0, 3'd7, 32'h7fffffff, 20'h64a9f, 32'h80000000, 20'h9b561);
        send_joint(-32'sd5);
        set_link(1, 3'd5, 32'h7fffffff, 32'd205888, 32'h80000000, 32'd102945);
        send_joint(32'sd1);
    endtask

    task automatic test_random_phases();
        logic signed [31:0] q;
        for (int p = 0; p < 11; p++)
        begin
            set_link($urandom_range(0, 1), 3'($urandom_range(0, 7)), $urandom(),
                     32'(random_angle()), $urandom(), 32'(random_angle()));
            for (int n = 0; n < 20; n++)
            begin
                q = (m_free == dlt_pkg::FREE_TWIST || m_free == dlt_pkg::FREE_ANGLE) ?
                    random_angle() : $urandom();
                send_joint(q);
            end
        end
    endtask

    task automatic test_output_backpressure();
        set_link(0, dlt_pkg::FREE_ANGLE, 32'h00010000, 32'd51472, 32'hfff00000, 0);
        burst_mode = 0;
        hold_off = 1;
        for (int n = 0; n < 40; n++) send_joint(random_angle());
        burst_mode = 1;
    endtask

    initial
    begin
        int hold;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1;
                for (hold = 0; hold < 300; hold++) @(posedge clk);
                hold_off = 0;
                out_stall <= 0;
            end
            else
                out_stall <= ($urandom_range(0, 15) < 4) && ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        row_t x;
        if (rst_n && out_valid && !out_stall)
        begin
            rows_seen++;
            if (expected_rows.size() == 0)
            begin
                $error("unexpected row %0d", row_index);
                error_count++;
            end
            else
            begin
                x = expected_rows.pop_front();
                if (row_index !== x.row)
                begin
                    $error("row_index exp %0d got %0d", x.row, row_index);
                    error_count++;
                end
                if (rot_col0 !== x.c0)
                begin
                    $error("rot_col0 exp %0d got %0d", x.c0, rot_col0);
                    error_count++;
                end
                if (rot_col1 !== x.c1)
                begin
                    $error("rot_col1 exp %0d got %0d", x.c1, rot_col1);
                    error_count++;
                end
                if (rot_col2 !== x.c2)
                begin
                    $error("rot_col2 exp %0d got %0d", x.c2, rot_col2);
                    error_count++;
                end
                if (trans_part !== x.tr)
                begin
                    $error("trans_part exp %0d got %0d", x.tr, trans_part);
                    error_count++;
                end
                if (last_row !== x.last)
                begin
                    $error("last_row exp %0d got %0d", x.last, last_row);
                    error_count++;
                end
                if (written !== x.wr)
                begin
                    $error("written exp %0d got %0d", x.wr, written);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d rows pending", expected_rows.size());
            $display("** dh_link_transform: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = dlt_pkg::REG_CONVENTION;
        cfg_data = 0;
        in_valid = 0;
        joint_value = 0;
        out_stall = 0;
        m_conv = 1;
        m_free = 0;
        m_len = 0;
        m_twist = 0;
        m_offs = 0;
        m_theta = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_extremes();
        test_output_backpressure();
        test_random_phases();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d joint values and checked %0d rows over both conventions,",
                 joints_sent, rows_seen);
        $display("every free selection and a long output hold-off.");
        if (error_count == 0 && expected_rows.size() == 0)
            $display("** dh_link_transform: PASSED **");
        else
            $display("** dh_link_transform: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dlt_pkg.sv
hdl/dlt_front.sv
hdl/dlt_queue.sv
hdl/dlt_cordic.sv
hdl/dlt_emit.sv
hdl/dh_link_transform.sv
verif/tb_top.sv
